>>> rtl/core/dqne_pkg.sv
// shared types and constants for the dns query name extractor
`default_nettype none
package dqne_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  localparam int ETH_HDR    = 14;
  localparam int IP_MIN_HDR = 20;
  localparam int UDP_HDR    = 8;
  localparam int DNS_HDR    = 12;

  localparam logic [15:0] FRAG_MASK      = 16'h1FFF;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] DEFAULT_PORT   = 16'd53;
  localparam logic [7:0]  DOT_CHAR       = 8'd46;

  typedef enum logic [2:0] {
    PH_ETH    = 3'd0,
    PH_IP     = 3'd1,
    PH_UDP    = 3'd2,
    PH_DNSHDR = 3'd3,
    PH_LEN    = 3'd4,
    PH_CHARS  = 3'd5,
    PH_IGNORE = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic        frame_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  name_char;
    logic        name_done;
    logic [31:0] source_addr;
    logic [7:0]  name_length;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/dns_query_name_extractor_unit.sv
// top level of the dns query name extractor
//
// in_valid/in_ready/in_beat carry one ethernet frame byte per beat, with
// the frame length and a last flag. out_valid/out_ready/out_beat carry
// the decoded name: one beat per character or dot, then an end record
// with the ipv4 source address and name length. frames that are not
// ipv4/udp to the configured port give no beats.
// cfg_wr_en/cfg_wr_data write the udp port; reset value is 53.
// an accepted beat lands in the input register, is parsed from there
// and its result is registered in the output register, from which the
// receiver takes it.
// throughput is one byte per cycle while no result waits on a stalled
// receiver; bytes with no result never wait on the receiver. when the
// receiver stalls with a result pending, one more byte is held in the
// input register, then in_ready drops. synchronous active-low reset
// clears both registers, the parser state and restores the port to 53.
`default_nettype none
module dns_query_name_extractor_unit #(
  parameter int LENGTH_BITS = dqne_pkg::LENGTH_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dqne_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  wire                 out_ready,
  output dqne_pkg::out_beat_t out_beat,
  input  wire                 cfg_wr_en,
  input  wire  [15:0]         cfg_wr_data
);
  import dqne_pkg::*;

  logic [15:0] match_port_r;
  logic        s1_valid;
  in_beat_t    s1_beat;
  res_t        res;
  logic        out_free;
  logic        fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r <= DEFAULT_PORT;
    end else if (cfg_wr_en) begin
      match_port_r <= cfg_wr_data;
    end
  end

  assign fire = s1_valid && (!res.valid || out_free);

  dqne_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .take_i   (fire),
    .valid_o  (s1_valid),
    .beat_o   (s1_beat)
  );

  dqne_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .beat_i       (s1_beat),
    .fire_i       (fire),
    .match_port_i (match_port_r),
    .res_o        (res)
  );

  dqne_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_i     (res),
    .fire_i    (fire),
    .free_o    (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule
`default_nettype wire

>>> rtl/core/dqne_in_stage.sv
// input register stage holding one accepted frame beat
`default_nettype none
module dqne_in_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dqne_pkg::in_beat_t  in_beat,
  input  wire                 take_i,
  output logic                valid_o,
  output dqne_pkg::in_beat_t  beat_o
);
  import dqne_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_beat_t beat_r;

  assign in_ready  = !valid_r || take_i;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !take_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign valid_o = valid_r;
  assign beat_o  = beat_r;

endmodule
`default_nettype wire

>>> rtl/core/dqne_parser.sv
// per-frame header parser and dns label decoder
`default_nettype none
module dqne_parser #(
  parameter int LENGTH_BITS = dqne_pkg::LENGTH_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  dqne_pkg::in_beat_t  beat_i,
  input  wire                 fire_i,
  input  wire  [15:0]         match_port_i,
  output dqne_pkg::res_t      res_o
);
  import dqne_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [15:0]            ether_kind_r, ether_kind_nxt;
  logic [5:0]             ip_header_bytes_r, ip_header_bytes_nxt;
  logic [15:0]            ip_total_bytes_r, ip_total_bytes_nxt;
  logic [15:0]            fragment_word_r, fragment_word_nxt;
  logic [7:0]             ip_protocol_r, ip_protocol_nxt;
  logic [31:0]            saved_source_r, saved_source_nxt;
  logic [15:0]            udp_dest_port_r, udp_dest_port_nxt;
  logic [7:0]             label_remaining_r, label_remaining_nxt;
  logic [7:0]             chars_emitted_r, chars_emitted_nxt;

  logic [7:0]             b;
  logic [LENGTH_BITS-1:0] flen;
  logic [LENGTH_BITS-1:0] off;
  logic [LENGTH_BITS-1:0] ip_rel;
  logic [LENGTH_BITS-1:0] udp_start;
  logic [LENGTH_BITS-1:0] udp_rel;
  logic                   ip_ok;
  logic [15:0]            ether_full;
  logic [15:0]            port_full;
  logic [7:0]             chars_inc;

  assign b         = beat_i.data_byte;
  assign flen      = beat_i.frame_length[LENGTH_BITS-1:0];
  assign off       = byte_offset_r;
  assign ip_rel    = off - LENGTH_BITS'(ETH_HDR);
  assign udp_start = LENGTH_BITS'(ETH_HDR) + LENGTH_BITS'(ip_header_bytes_r);
  assign udp_rel   = off - udp_start;
  assign chars_inc = (chars_emitted_r != 8'hFF) ? chars_emitted_r + 8'd1 : chars_emitted_r;
  assign ether_full = ether_kind_r | {8'h00, b};
  assign port_full  = udp_dest_port_r | {8'h00, b};

  assign ip_ok = (ip_header_bytes_r >= 6'(IP_MIN_HDR))
              && (flen >= LENGTH_BITS'(ETH_HDR + IP_MIN_HDR))
              && ({1'b0, ip_total_bytes_r} <= (17'(flen) - 17'(ETH_HDR)))
              && ((fragment_word_r & FRAG_MASK) == 16'h0000)
              && (ip_protocol_r == PROTO_UDP);

  always_comb begin
    phase_nxt           = phase_r;
    ether_kind_nxt      = ether_kind_r;
    ip_header_bytes_nxt = ip_header_bytes_r;
    ip_total_bytes_nxt  = ip_total_bytes_r;
    fragment_word_nxt   = fragment_word_r;
    ip_protocol_nxt     = ip_protocol_r;
    saved_source_nxt    = saved_source_r;
    udp_dest_port_nxt   = udp_dest_port_r;
    label_remaining_nxt = label_remaining_r;
    chars_emitted_nxt   = chars_emitted_r;
    byte_offset_nxt     = (byte_offset_r != LEN_MAX) ? byte_offset_r + 1'b1 : byte_offset_r;
    res_o               = '0;

    case (phase_r)
      PH_ETH: begin
        if (off == LENGTH_BITS'(12)) begin
          ether_kind_nxt = {b, 8'h00};
        end else if (off == LENGTH_BITS'(13)) begin
          ether_kind_nxt = ether_full;
          phase_nxt = (ether_full == ETHERTYPE_IPV4) ? PH_IP : PH_IGNORE;
        end
      end
      PH_IP: begin
        if (ip_rel == LENGTH_BITS'(0)) begin
          ip_header_bytes_nxt = {b[3:0], 2'b00};
        end else if (ip_rel == LENGTH_BITS'(2)) begin
          ip_total_bytes_nxt = {b, 8'h00};
        end else if (ip_rel == LENGTH_BITS'(3)) begin
          ip_total_bytes_nxt = ip_total_bytes_r | {8'h00, b};
        end else if (ip_rel == LENGTH_BITS'(6)) begin
          fragment_word_nxt = {b, 8'h00};
        end else if (ip_rel == LENGTH_BITS'(7)) begin
          fragment_word_nxt = fragment_word_r | {8'h00, b};
        end else if (ip_rel == LENGTH_BITS'(9)) begin
          ip_protocol_nxt = b;
        end else if (ip_rel >= LENGTH_BITS'(12) && ip_rel <= LENGTH_BITS'(15)) begin
          saved_source_nxt = {saved_source_r[23:0], b};
        end
        if (ip_rel == LENGTH_BITS'(IP_MIN_HDR - 1)) begin
          phase_nxt = ip_ok ? PH_UDP : PH_IGNORE;
        end
      end
      PH_UDP: begin
        if (off >= udp_start) begin
          if (udp_rel == LENGTH_BITS'(2)) begin
            udp_dest_port_nxt = {b, 8'h00};
          end else if (udp_rel == LENGTH_BITS'(3)) begin
            udp_dest_port_nxt = port_full;
            phase_nxt = (port_full == match_port_i) ? PH_DNSHDR : PH_IGNORE;
          end
        end
      end
      PH_DNSHDR: begin
        if (udp_rel == LENGTH_BITS'(UDP_HDR + DNS_HDR - 1)) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b == 8'h00) begin
          res_o.valid            = 1'b1;
          res_o.beat.name_done   = 1'b1;
          res_o.beat.source_addr = saved_source_r;
          res_o.beat.name_length = chars_emitted_r;
          phase_nxt              = PH_IGNORE;
        end else if (beat_i.frame_last) begin
          res_o.valid            = 1'b1;
          res_o.beat.name_done   = 1'b1;
          res_o.beat.source_addr = saved_source_r;
          res_o.beat.name_length = chars_emitted_r;
        end else begin
          label_remaining_nxt = b;
          phase_nxt           = PH_CHARS;
          if (chars_emitted_r != 8'h00) begin
            res_o.valid          = 1'b1;
            res_o.beat.name_char = DOT_CHAR;
            chars_emitted_nxt    = chars_inc;
          end
        end
      end
      PH_CHARS: begin
        if (beat_i.frame_last) begin
          res_o.valid            = 1'b1;
          res_o.beat.name_done   = 1'b1;
          res_o.beat.source_addr = saved_source_r;
          res_o.beat.name_length = chars_emitted_r;
        end else begin
          res_o.valid          = 1'b1;
          res_o.beat.name_char = b;
          chars_emitted_nxt    = chars_inc;
          label_remaining_nxt  = label_remaining_r - 8'd1;
          if (label_remaining_r == 8'd1) begin
            phase_nxt = PH_LEN;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire_i && beat_i.frame_last)) begin
      phase_r           <= PH_ETH;
      byte_offset_r     <= '0;
      ether_kind_r      <= '0;
      ip_header_bytes_r <= '0;
      ip_total_bytes_r  <= '0;
      fragment_word_r   <= '0;
      ip_protocol_r     <= '0;
      saved_source_r    <= '0;
      udp_dest_port_r   <= '0;
      label_remaining_r <= '0;
      chars_emitted_r   <= '0;
    end else if (fire_i) begin
      phase_r           <= phase_nxt;
      byte_offset_r     <= byte_offset_nxt;
      ether_kind_r      <= ether_kind_nxt;
      ip_header_bytes_r <= ip_header_bytes_nxt;
      ip_total_bytes_r  <= ip_total_bytes_nxt;
      fragment_word_r   <= fragment_word_nxt;
      ip_protocol_r     <= ip_protocol_nxt;
      saved_source_r    <= saved_source_nxt;
      udp_dest_port_r   <= udp_dest_port_nxt;
      label_remaining_r <= label_remaining_nxt;
      chars_emitted_r   <= chars_emitted_nxt;
    end
  end

`ifndef SYNTH
  a_res_only_in_name: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.valid |-> (phase_r == PH_LEN || phase_r == PH_CHARS))
    else $error("result outside name phases");

  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (res_o.valid && res_o.beat.name_done) |-> (res_o.beat.name_char == 8'h00))
    else $error("end record carries a character");

  a_char_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (res_o.valid && !res_o.beat.name_done)
      |-> (res_o.beat.source_addr == 32'h0 && res_o.beat.name_length == 8'h00))
    else $error("character record carries end fields");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_i && beat_i.frame_last) |=> (phase_r == PH_ETH && byte_offset_r == '0))
    else $error("frame state not cleared after last beat");
`endif

endmodule
`default_nettype wire

>>> rtl/core/dqne_out_stage.sv
// result register holding one decoded beat for the receiver
`default_nettype none
module dqne_out_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  dqne_pkg::res_t      res_i,
  input  wire                 fire_i,
  output logic                free_o,
  output logic                out_valid,
  input  wire                 out_ready,
  output dqne_pkg::out_beat_t out_beat
);
  import dqne_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  logic      load;
  out_beat_t beat_r;

  assign free_o    = !valid_r || out_ready;
  assign load      = fire_i && res_i.valid;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= res_i.beat;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule
`default_nettype wire

>>> dv/dns_query_name_extractor_unit_tb.sv
// self-checking testbench for the dns query name extractor: random frames, port settings, stalls
module dns_query_name_extractor_unit_tb;
  import dqne_pkg::*;

  localparam int FROM_SIZE = -1;
  localparam int UNPATCHED = -2;
  localparam int WHOLE     = 0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_beat = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_beat;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  dns_query_name_extractor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_beat_t    frame_bytes[$];
  out_beat_t   name_beats_due[$];
  logic [7:0]  pkt[$];

  // parser state mirrored from the block
  phase_t      ph;
  logic [15:0] boff, ekind, itot, frag_w, dport_w, port_cfg;
  logic [5:0]  ihl_b;
  logic [7:0]  proto_b, lrem, nchars;
  logic [31:0] src_w;

  logic [15:0] port_now = DEFAULT_PORT;
  int          in_gap = 0, out_hold = 0, errors = 0;
  int          frames_sent = 0, bytes_taken = 0, chars_seen = 0, names_seen = 0;
  bit          in_took = 1'b0, in_calm = 1'b0, out_calm = 1'b0, rush = 1'b0;

  function automatic void clear_frame_state();
    ph = PH_ETH;
    boff = '0;
    ekind = '0;
    ihl_b = '0;
    itot = '0;
    frag_w = '0;
    proto_b = '0;
    src_w = '0;
    dport_w = '0;
    lrem = '0;
    nchars = '0;
  endfunction

  function automatic bit extract_step(input in_beat_t bt, output out_beat_t r);
    logic [7:0] b;
    int off, rel, ustart;
    bit hit;
    b = bt.data_byte;
    off = int'(boff);
    ustart = ETH_HDR + int'(ihl_b);
    hit = 1'b0;
    r = '0;
    case (ph)
      PH_ETH: begin
        if (off == 12) begin
          ekind = {b, 8'h00};
        end else if (off == 13) begin
          ekind[7:0] = b;
          ph = (ekind == ETHERTYPE_IPV4) ? PH_IP : PH_IGNORE;
        end
      end
      PH_IP: begin
        rel = off - ETH_HDR;
        if (rel == 0) ihl_b = {b[3:0], 2'b00};
        else if (rel == 2) itot = {b, 8'h00};
        else if (rel == 3) itot[7:0] = b;
        else if (rel == 6) frag_w = {b, 8'h00};
        else if (rel == 7) frag_w[7:0] = b;
        else if (rel == 9) proto_b = b;
        else if (rel >= 12 && rel <= 15) src_w = {src_w[23:0], b};
        if (rel == IP_MIN_HDR - 1) begin
          ph = (ihl_b >= IP_MIN_HDR && bt.frame_length >= ETH_HDR + IP_MIN_HDR
                && int'(itot) <= int'(bt.frame_length) - ETH_HDR
                && (frag_w & FRAG_MASK) == 16'h0 && proto_b == PROTO_UDP)
               ? PH_UDP : PH_IGNORE;
        end
      end
      PH_UDP: begin
        if (off >= ustart) begin
          rel = off - ustart;
          if (rel == 2) begin
            dport_w = {b, 8'h00};
          end else if (rel == 3) begin
            dport_w[7:0] = b;
            ph = (dport_w == port_cfg) ? PH_DNSHDR : PH_IGNORE;
          end
        end
      end
      PH_DNSHDR: begin
        if (off == ustart + UDP_HDR + DNS_HDR - 1) ph = PH_LEN;
      end
      PH_LEN, PH_CHARS: begin
        if (ph == PH_LEN && b == 8'h00 || bt.frame_last) begin
          // end record, also for a name cut off by the frame end
          r.name_done = 1'b1;
          r.source_addr = src_w;
          r.name_length = nchars;
          hit = 1'b1;
          if (b == 8'h00 && ph == PH_LEN) ph = PH_IGNORE;
        end else if (ph == PH_LEN) begin
          lrem = b;
          ph = PH_CHARS;
          if (nchars != 8'd0) begin
            r.name_char = DOT_CHAR;
            hit = 1'b1;
            if (nchars != 8'hFF) nchars++;
          end
        end else begin
          r.name_char = b;
          hit = 1'b1;
          if (nchars != 8'hFF) nchars++;
          lrem = lrem - 8'd1;
          if (lrem == 8'd0) ph = PH_LEN;
        end
      end
      default: ;
    endcase
    if (boff != 16'hFFFF) boff++;
    if (bt.frame_last) clear_frame_state();
    return hit;
  endfunction

  function automatic int pick_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return (calm || rush) ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    errors++;
    if (errors <= 100)
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, exp_v, act_v);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (frame_bytes.size() > 0) begin
        in_beat <= frame_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : track
    out_beat_t want;
    if (!rst_n) begin
      clear_frame_state();
      port_cfg = DEFAULT_PORT;
    end else begin
      if (cfg_wr_en) port_cfg = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (extract_step(in_beat, want)) name_beats_due.push_back(want);
        bytes_taken++;
        in_took = 1'b1;
        in_gap = pick_wait(in_calm);
      end
      if (out_valid && out_ready) begin
        out_hold = pick_wait(out_calm);
        if (name_beats_due.size() == 0) begin
          errors++;
          if (errors <= 100) $display("%0t name beat with nothing pending: %h", $time, out_beat);
        end else begin
          want = name_beats_due.pop_front();
          if (want.name_done) names_seen++;
          else chars_seen++;
          if (out_beat.name_char !== want.name_char)
            flag_mismatch("name_char", 32'(want.name_char), 32'(out_beat.name_char));
          if (out_beat.name_done !== want.name_done)
            flag_mismatch("name_done", 32'(want.name_done), 32'(out_beat.name_done));
          if (out_beat.source_addr !== want.source_addr)
            flag_mismatch("source_addr", want.source_addr, out_beat.source_addr);
          if (out_beat.name_length !== want.name_length)
            flag_mismatch("name_length", 32'(want.name_length), 32'(out_beat.name_length));
        end
      end
    end
  end

  task automatic put_rand(input int n);
    repeat (n) pkt.push_back(8'($urandom));
  endtask

  task automatic put_bytes(input logic [31:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) pkt.push_back(v[8*i +: 8]);
  endtask

  task automatic build_header(input logic [15:0] etype, input logic [3:0] ihl_w,
                              input logic [15:0] frag, input logic [7:0] proto,
                              input logic [31:0] src, input logic [15:0] dport);
    pkt.delete();
    put_rand(12);
    put_bytes(32'(etype), 2);
    pkt.push_back({4'h4, ihl_w});
    put_rand(1);
    put_bytes(32'h0, 2);
    put_rand(2);
    put_bytes(32'(frag), 2);
    put_rand(1);
    pkt.push_back(proto);
    put_rand(2);
    put_bytes(src, 4);
    put_rand(4);
    if (ihl_w > 5) put_rand(4 * ihl_w - 20);
    put_rand(2);
    put_bytes(32'(dport), 2);
    put_rand(4 + DNS_HDR);
  endtask

  task automatic add_label(input int len);
    pkt.push_back(8'(len));
    put_rand(len);
  endtask

  task automatic add_name(input int nlab, input int maxlen);
    int k;
    for (k = 0; k < nlab; k++)
      add_label(($urandom_range(0, 29) == 0) ? $urandom_range(64, 255)
                                              : $urandom_range(1, maxlen));
    pkt.push_back(8'h00);
    put_rand(4);
  endtask

  task automatic query(input logic [15:0] etype, input logic [3:0] ihl_w,
                       input logic [15:0] frag, input logic [7:0] proto,
                       input logic [15:0] dport);
    build_header(etype, ihl_w, frag, proto, 32'($urandom), dport);
    add_name($urandom_range(1, 3), 6);
  endtask

  // queues the frame in pkt, optionally cut short, with the ip total length patched in unless left unpatched
  task automatic ship(input int flen, input int keep, input int tot);
    in_beat_t bt;
    int i, n, t;
    n = (keep > 0 && keep < pkt.size()) ? keep : pkt.size();
    t = (tot == FROM_SIZE) ? pkt.size() - ETH_HDR : tot;
    if (tot != UNPATCHED && pkt.size() >= 18) begin
      pkt[16] = t[15:8];
      pkt[17] = t[7:0];
    end
    for (i = 0; i < n; i++) begin
      bt.data_byte = pkt[i];
      bt.frame_length = 16'((flen < 0) ? pkt.size() : flen);
      bt.frame_last = (i == n - 1);
      frame_bytes.push_back(bt);
    end
    frames_sent++;
  endtask

  task automatic random_phase(input int want_bytes);
    int sent, kind, flen, keep, tot, hdr;
    logic [15:0] etype, frag, dport;
    logic [3:0]  ihl_w;
    logic [7:0]  proto;
    sent = 0;
    while (sent < want_bytes) begin
      kind = $urandom_range(0, 99);
      etype = ETHERTYPE_IPV4;
      proto = PROTO_UDP;
      dport = port_now;
      frag = {3'($urandom), 13'h0};
      ihl_w = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      flen = FROM_SIZE;
      keep = WHOLE;
      tot = FROM_SIZE;
      if (kind < 8) begin
        pkt.delete();
        put_rand($urandom_range(1, 48));
        ship($urandom_range(0, 65535), WHOLE, UNPATCHED);
      end else begin
        if (kind < 14) etype = 16'($urandom);
        else if (kind < 20) proto = 8'($urandom);
        else if (kind < 26) frag[12:0] = 13'($urandom_range(1, 8191));
        else if (kind < 32) dport = 16'($urandom);
        else if (kind < 36) ihl_w = 4'($urandom_range(0, 4));
        build_header(etype, ihl_w, frag, proto, 32'($urandom), dport);
        hdr = pkt.size();
        add_name($urandom_range(0, 4), $urandom_range(1, 12));
        if (kind >= 36 && kind < 42) flen = $urandom_range(0, 40);
        else if (kind >= 42 && kind < 48) tot = pkt.size() - ETH_HDR + $urandom_range(1, 300);
        else if (kind >= 48 && kind < 64)
          keep = $urandom_range(0, 1) ? $urandom_range(hdr - 2, pkt.size())
                                      : $urandom_range(1, pkt.size());
        else if ($urandom_range(0, 3) == 0) flen = $urandom_range(pkt.size(), 65535);
        ship(flen, keep, tot);
        sent += (keep > 0) ? keep : pkt.size();
      end
    end
  endtask

  task automatic drain();
    while (frame_bytes.size() > 0 || in_valid || name_beats_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_port(input logic [15:0] p);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    port_now = p;
  endtask

  initial begin
    logic [15:0] ports[4];
    int hdr, k;
    ports[0] = 16'h0000;
    ports[1] = 16'hFFFF;
    ports[2] = 16'($urandom);
    ports[3] = DEFAULT_PORT;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // label with both byte extremes, then more labels
    build_header(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, 32'hFFFF_FFFF, port_now);
    pkt.push_back(8'd2);
    pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    add_name(2, 6);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    // empty name
    build_header(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, 32'h0, port_now);
    add_name(0, 1);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    // frame ends inside a label
    build_header(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, 32'($urandom), port_now);
    hdr = pkt.size();
    add_label(5);
    add_name(1, 4);
    ship(FROM_SIZE, hdr + 4, FROM_SIZE);
    // frame ends on a length byte
    build_header(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, 32'($urandom), port_now);
    hdr = pkt.size();
    add_label(3);
    add_label(4);
    ship(FROM_SIZE, hdr + 5, FROM_SIZE);
    // frame ends on the terminating zero
    build_header(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, 32'($urandom), port_now);
    hdr = pkt.size();
    add_label(4);
    add_name(0, 1);
    ship(FROM_SIZE, hdr + 6, FROM_SIZE);
    // pointer-like length byte and a name long enough to saturate the count
    build_header(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, 32'($urandom), port_now);
    add_label(192);
    add_label(63);
    add_label(10);
    add_name(1, 8);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd4, 16'h0, PROTO_UDP, port_now);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd15, 16'h0, PROTO_UDP, port_now);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    query(16'h86DD, 4'd5, 16'h0, PROTO_UDP, port_now);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd5, 16'h0, 8'd6, port_now);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd5, 16'h0001, PROTO_UDP, port_now);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd5, 16'hE000, PROTO_UDP, port_now);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, port_now);
    ship(FROM_SIZE, WHOLE, pkt.size() - ETH_HDR + 1);
    query(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, port_now);
    ship(33, WHOLE, 19);
    query(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, port_now);
    ship(0, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, port_now);
    ship(65535, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, port_now ^ 16'h0001);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    query(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, port_now);
    ship(FROM_SIZE, 21, FROM_SIZE);
    pkt.delete();
    put_rand(1);
    ship(FROM_SIZE, WHOLE, UNPATCHED);
    build_header(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, 32'($urandom), port_now);
    hdr = pkt.size();
    add_name(1, 5);
    ship(FROM_SIZE, hdr - 3, FROM_SIZE);
    drain();

    // a query with no idling on either side
    rush = 1'b1;
    query(ETHERTYPE_IPV4, 4'd5, 16'h0, PROTO_UDP, port_now);
    ship(FROM_SIZE, WHOLE, FROM_SIZE);
    drain();
    rush = 1'b0;

    for (k = 0; k < 4; k++) begin
      write_port(ports[k]);
      random_phase(225);
      drain();
    end

    $display("ran %0d frames, %0d bytes, over ports 53, 0, 65535, %0d and 53",
             frames_sent, bytes_taken, ports[2]);
    $display("checked %0d name characters and %0d end records", chars_seen, names_seen);
    if (errors == 0 && name_beats_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d name beats outstanding", name_beats_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
